FILE: rtl/core/polygon_solid_angle_assert.svh
// Assertion macros shared by the polygon solid angle RTL.
// Uses the clk and rst signals of the module that expands them.
`ifndef POLYGON_SOLID_ANGLE_ASSERT_SVH
`define POLYGON_SOLID_ANGLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PSA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define PSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define PSA_ASSERT_IMP(lbl, ante, cons)
`define PSA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/psa_pkg.sv
// Package for the polygon solid angle block: types, angle constants and
// the arithmetic step functions of the square root and CORDIC stages.
package psa_pkg;

  localparam int IDX_W        = 4;
  localparam int CNT_W        = 5;
  localparam int ANG_W        = 31;
  localparam int MIN_VERTICES = 3;
  localparam int SC_W         = 15;
  localparam int SCALE_BITS   = 14;
  localparam int CR_W         = 31;
  localparam int DET_W        = 48;
  localparam int DOT_W        = 64;
  localparam int ISQ_W        = 32;
  localparam int ISQ_TOP      = 28;
  localparam int ISQ_ST       = 5;
  localparam int ISQ_PER      = 3;
  localparam int NORM_BITS    = 30;
  localparam int ATAN_IN_W    = 31;
  localparam int CX_W         = 34;
  localparam int Z_W          = 32;
  localparam int CS_ST        = 14;
  localparam int CS_PER       = 2;

  localparam int ANG_PI_HALF = 210828714;
  localparam int ANG_TWO_PI  = 843314857;
  localparam int ANG_FOUR_PI = 1686629714;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } psa_func_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic degen;
  } psa_ctl_t;

  typedef struct packed {
    logic             clipped;
    logic             degenerate;
    logic [ANG_W-1:0] offset_angle;
    logic [ANG_W-1:0] wrapped_angle;
  } psa_result_t;

  typedef struct packed {
    logic [ISQ_W-1:0] v;
    logic [ISQ_W-1:0] r;
  } psa_isq_t;

  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } psa_cordic_t;

  function automatic psa_isq_t isqrt_step(input psa_isq_t s, input int n);
    logic [ISQ_W-1:0] bitv;
    logic [ISQ_W-1:0] sum;
    psa_isq_t o;
    bitv = ISQ_W'(1) << (ISQ_TOP - 2 * n);
    sum = s.r + bitv;
    if (s.v >= sum) begin
      o.v = s.v - sum;
      o.r = (s.r >> 1) + bitv;
    end else begin
      o.v = s.v;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  function automatic logic signed [Z_W-1:0] atan_val(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:  v = Z_W'(105414357);
      1:  v = Z_W'(62229729);
      2:  v = Z_W'(32880480);
      3:  v = Z_W'(16690645);
      4:  v = Z_W'(8377711);
      5:  v = Z_W'(4192939);
      6:  v = Z_W'(2096981);
      7:  v = Z_W'(1048555);
      8:  v = Z_W'(524285);
      9:  v = Z_W'(262144);
      10: v = Z_W'(131072);
      11: v = Z_W'(65536);
      12: v = Z_W'(32768);
      13: v = Z_W'(16384);
      14: v = Z_W'(8192);
      15: v = Z_W'(4096);
      16: v = Z_W'(2048);
      17: v = Z_W'(1024);
      18: v = Z_W'(512);
      19: v = Z_W'(256);
      20: v = Z_W'(128);
      21: v = Z_W'(64);
      22: v = Z_W'(32);
      23: v = Z_W'(16);
      24: v = Z_W'(8);
      25: v = Z_W'(4);
      26: v = Z_W'(2);
      27: v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic psa_cordic_t cordic_step(input psa_cordic_t s, input int i);
    logic signed [CX_W-1:0] xs;
    logic signed [CX_W-1:0] ys;
    psa_cordic_t o;
    xs = s.x >>> i;
    ys = s.y >>> i;
    if (!s.y[CX_W-1]) begin
      o.x = s.x + ys;
      o.y = s.y - xs;
      o.z = s.z + atan_val(i);
    end else begin
      o.x = s.x - ys;
      o.y = s.y + xs;
      o.z = s.z - atan_val(i);
    end
    return o;
  endfunction

endpackage

FILE: rtl/core/psa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; used for the vertex table.
module psa_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/psa_vertex_pipe.sv
// Per-vertex geometry pipeline: differences, exact degenerate test, scaling,
// plane normals, determinant, dot product and |b|. Depends on psa_pkg.
module psa_vertex_pipe import psa_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  psa_ctl_t                  in_ctl,
  input  logic [3*COORD_BITS-1:0]   p0,
  input  logic [3*COORD_BITS-1:0]   p1,
  input  logic [3*COORD_BITS-1:0]   p2,
  input  logic [3*COORD_BITS-1:0]   q,
  output psa_ctl_t                  out_ctl,
  output logic signed [DOT_W-1:0]   out_x,
  output logic signed [DOT_W-1:0]   out_y
);

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SH_W   = $clog2(DIFF_W + 1);
  localparam int PR_W   = 2 * DIFF_W;

  function automatic logic [DIFF_W-1:0] fold_d(input logic signed [DIFF_W-1:0] v);
    return v[DIFF_W-1] ? ~v : v;
  endfunction

  psa_ctl_t c1, c2, c3, c4, c10;
  logic signed [DIFF_W-1:0] a1 [3], b1 [3], d1 [3];
  logic signed [DIFF_W-1:0] a2 [3], b2 [3], d2 [3];
  logic signed [PR_W-1:0]   lab [3], rab [3], lbc [3], rbc [3];
  logic [DIFF_W-1:0]        mag;
  logic [SH_W-1:0]          nb;
  logic [SH_W-1:0]          sh_next;
  logic [SH_W-1:0]          sh2;
  logic                     deg_next;
  logic signed [DIFF_W-1:0] ta [3], tb [3], td [3];
  logic signed [SC_W-1:0]   sa3 [3], sb3 [3], sc3 [3];
  logic signed [CR_W-1:0]   uu4 [3], vv4 [3];
  logic signed [SC_W-1:0]   sa4 [3];
  logic signed [ISQ_W-1:0]  bb_s;
  logic [ISQ_W-1:0]         bb4;
  logic signed [DET_W-1:0]  pd5 [3];
  logic signed [DOT_W-1:0]  pp5 [3];
  logic signed [DET_W-1:0]  det6;
  logic signed [DOT_W-1:0]  dot6;
  logic signed [DET_W-1:0]  det_d [3];
  logic signed [DOT_W-1:0]  dot_d [3];
  logic signed [DET_W-1:0]  ndet;
  logic signed [SC_W:0]     k_s;
  psa_isq_t                 isq [ISQ_ST+1];
  psa_ctl_t                 isq_c [ISQ_ST+1];

  // Stage 1: differences to the query point.
  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
    end else begin
      c1 <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      a1[j] <= DIFF_W'(signed'(p0[j*COORD_BITS +: COORD_BITS]))
             - DIFF_W'(signed'(q[j*COORD_BITS +: COORD_BITS]));
      b1[j] <= DIFF_W'(signed'(p1[j*COORD_BITS +: COORD_BITS]))
             - DIFF_W'(signed'(q[j*COORD_BITS +: COORD_BITS]));
      d1[j] <= DIFF_W'(signed'(p2[j*COORD_BITS +: COORD_BITS]))
             - DIFF_W'(signed'(q[j*COORD_BITS +: COORD_BITS]));
    end
  end

  // Stage 2: full-width cross products and the common scaling shift.
  always_comb begin
    mag = '0;
    for (int j = 0; j < 3; j++) begin
      mag = mag | fold_d(a1[j]) | fold_d(b1[j]) | fold_d(d1[j]);
    end
    nb = '0;
    for (int k = 0; k < DIFF_W; k++) begin
      if (mag[k]) begin
        nb = SH_W'(k + 1);
      end
    end
    sh_next = (nb > SH_W'(SCALE_BITS)) ? nb - SH_W'(SCALE_BITS) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c2 <= '0;
    end else begin
      c2 <= c1;
    end
  end

  always_ff @(posedge clk) begin
    sh2 <= sh_next;
    for (int j = 0; j < 3; j++) begin
      a2[j]  <= a1[j];
      b2[j]  <= b1[j];
      d2[j]  <= d1[j];
      lab[j] <= a1[(j+1)%3] * b1[(j+2)%3];
      rab[j] <= a1[(j+2)%3] * b1[(j+1)%3];
      lbc[j] <= b1[(j+1)%3] * d1[(j+2)%3];
      rbc[j] <= b1[(j+2)%3] * d1[(j+1)%3];
    end
  end

  // Stage 3: zero test of both normals and the scaled operands.
  always_comb begin
    deg_next = ((lab[0] == rab[0]) && (lab[1] == rab[1]) && (lab[2] == rab[2])) ||
               ((lbc[0] == rbc[0]) && (lbc[1] == rbc[1]) && (lbc[2] == rbc[2]));
    for (int j = 0; j < 3; j++) begin
      ta[j] = a2[j] >>> sh2;
      tb[j] = b2[j] >>> sh2;
      td[j] = d2[j] >>> sh2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c3 <= '0;
    end else begin
      c3.valid <= c2.valid;
      c3.last  <= c2.last;
      c3.degen <= c2.degen | deg_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      sa3[j] <= ta[j][SC_W-1:0];
      sb3[j] <= tb[j][SC_W-1:0];
      sc3[j] <= td[j][SC_W-1:0];
    end
  end

  // Stage 4: plane normals and b.b.
  assign bb_s = sb3[0] * sb3[0] + sb3[1] * sb3[1] + sb3[2] * sb3[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      c4 <= '0;
    end else begin
      c4 <= c3;
    end
  end

  always_ff @(posedge clk) begin
    bb4 <= unsigned'(bb_s);
    for (int j = 0; j < 3; j++) begin
      sa4[j] <= sa3[j];
      uu4[j] <= sb3[(j+1)%3] * sc3[(j+2)%3] - sb3[(j+2)%3] * sc3[(j+1)%3];
      vv4[j] <= sa3[(j+1)%3] * sb3[(j+2)%3] - sa3[(j+2)%3] * sb3[(j+1)%3];
    end
  end

  // Stages 5 to 9: square root of b.b, three digits per stage.
  assign isq[0]   = '{v: bb4, r: '0};
  assign isq_c[0] = c4;

  for (genvar st = 0; st < ISQ_ST; st++) begin : g_isq
    psa_isq_t t;
    always_comb begin
      t = isq[st];
      for (int k = 0; k < ISQ_PER; k++) begin
        t = isqrt_step(t, st * ISQ_PER + k);
      end
    end
    always_ff @(posedge clk) begin
      isq[st+1] <= t;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        isq_c[st+1] <= '0;
      end else begin
        isq_c[st+1] <= isq_c[st];
      end
    end
  end

  // Determinant and dot product run beside the root and wait for it.
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      pd5[j] <= sa4[j] * uu4[j];
      pp5[j] <= uu4[j] * vv4[j];
    end
    det6 <= pd5[0] + pd5[1] + pd5[2];
    dot6 <= pp5[0] + pp5[1] + pp5[2];
    det_d[0] <= det6;
    dot_d[0] <= dot6;
    for (int j = 1; j < 3; j++) begin
      det_d[j] <= det_d[j-1];
      dot_d[j] <= dot_d[j-1];
    end
  end

  // Stage 10: atan2 operands.
  assign ndet = -det_d[2];
  assign k_s  = signed'({1'b0, isq[ISQ_ST].r[SC_W-1:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      c10 <= '0;
    end else begin
      c10 <= isq_c[ISQ_ST];
    end
  end

  always_ff @(posedge clk) begin
    out_y <= ndet * k_s;
    out_x <= dot_d[2];
  end

  assign out_ctl = c10;

endmodule

FILE: rtl/core/psa_cordic.sv
// Pipelined atan2: operand normalization, quadrant pre-rotation and
// vectoring CORDIC, two iterations per stage. Depends on psa_pkg.
module psa_cordic import psa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  psa_ctl_t                 in_ctl,
  input  logic signed [DOT_W-1:0]  in_x,
  input  logic signed [DOT_W-1:0]  in_y,
  output psa_ctl_t                 out_ctl,
  output logic signed [Z_W-1:0]    out_z
);

  localparam int NB_W = $clog2(DOT_W + 1);

  logic [DOT_W-1:0]            mag;
  logic [NB_W-1:0]             nb;
  logic [NB_W-1:0]             sh_next;
  psa_ctl_t                    c1, c2;
  logic signed [DOT_W-1:0]     x1, y1;
  logic [NB_W-1:0]             sh1;
  logic                        zero1, zero2;
  logic signed [DOT_W-1:0]     tx, ty;
  logic signed [ATAN_IN_W-1:0] x2, y2;
  logic signed [CX_W-1:0]      xe, ye;
  psa_cordic_t                 pre;
  psa_cordic_t                 cs [CS_ST+1];
  psa_ctl_t                    cc [CS_ST+1];
  logic                        zf [CS_ST+1];

  always_comb begin
    mag = (in_x[DOT_W-1] ? ~in_x : in_x) | (in_y[DOT_W-1] ? ~in_y : in_y);
    nb = '0;
    for (int k = 0; k < DOT_W; k++) begin
      if (mag[k]) begin
        nb = NB_W'(k + 1);
      end
    end
    sh_next = (nb > NB_W'(NORM_BITS)) ? nb - NB_W'(NORM_BITS) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
    end else begin
      c1 <= in_ctl;
      c2 <= c1;
    end
  end

  assign tx = x1 >>> sh1;
  assign ty = y1 >>> sh1;

  always_ff @(posedge clk) begin
    x1    <= in_x;
    y1    <= in_y;
    sh1   <= sh_next;
    zero1 <= (in_x == '0) && (in_y == '0);
    x2    <= tx[ATAN_IN_W-1:0];
    y2    <= ty[ATAN_IN_W-1:0];
    zero2 <= zero1;
  end

  assign xe = CX_W'(x2);
  assign ye = CX_W'(y2);

  always_comb begin
    if (x2 < 0) begin
      if (y2 >= 0) begin
        pre.x = ye;
        pre.y = -xe;
        pre.z = Z_W'(ANG_PI_HALF);
      end else begin
        pre.x = -ye;
        pre.y = xe;
        pre.z = -Z_W'(ANG_PI_HALF);
      end
    end else begin
      pre.x = xe;
      pre.y = ye;
      pre.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    cs[0] <= pre;
    zf[0] <= zero2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cc[0] <= '0;
    end else begin
      cc[0] <= c2;
    end
  end

  for (genvar st = 0; st < CS_ST; st++) begin : g_cs
    psa_cordic_t t;
    always_comb begin
      t = cs[st];
      for (int k = 0; k < CS_PER; k++) begin
        t = cordic_step(t, st * CS_PER + k);
      end
    end
    always_ff @(posedge clk) begin
      cs[st+1] <= t;
      zf[st+1] <= zf[st];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        cc[st+1] <= '0;
      end else begin
        cc[st+1] <= cc[st];
      end
    end
  end

  assign out_ctl = cc[CS_ST];
  assign out_z   = zf[CS_ST] ? '0 : cs[CS_ST].z;

endmodule

FILE: rtl/core/polygon_solid_angle.sv
// Solid angle of a closed polygon seen from a query point.
//
// Input stream s_*: s_tuser selects a vertex load (0) or a query (1). A load
// writes one vertex into the table and gives no result. A query gives one
// result on m_*. Register vertex_count is written through cfg_*; the user
// must do so only while the block is idle, which the block does not enforce.
// cfg_ready is high outside reset. A query walks the vertex table through
// one RAM read port, one vertex per cycle, n + 2 reads for n vertices, into
// a 10-stage geometry pipeline and a 17-stage CORDIC pipeline. One query is
// in flight at a time; s_tready is low from the query transaction until its
// result moves into the output register.
// Reset clears control state and sets vertex_count to 4; the vertex table
// holds no value until written and needs no clearing. If the receiver
// stalls, the result waits in the output register and one more finished
// result waits behind it; loads and one new query are still taken while
// only the output register is full.
// Depends on psa_pkg, psa_ram, psa_vertex_pipe and psa_cordic.
`include "polygon_solid_angle_assert.svh"
module polygon_solid_angle import psa_pkg::*; #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // vertex_index [3:0], point_x, point_y, point_z, then zero padding
  input  logic [((IDX_W + 3*COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // func
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // wrapped_angle [30:0], offset_angle [61:31], degenerate [62], clipped [63]
  output logic [2*ANG_W+1:0]    m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CNT_W-1:0]      cfg_data
);

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int NW    = $clog2(MAX_VERTICES + 2);
  localparam int VW    = 3 * COORD_BITS;
  localparam int SUM_W = Z_W + $clog2(MAX_VERTICES) + 1;
  localparam int OFF_W = SUM_W + 1;
  localparam int WT_W  = ANG_W + 3;

  logic [CNT_W-1:0]        vertex_count;
  logic                    busy;
  logic                    issuing;
  logic [NW-1:0]           iss_cnt;
  logic [NW-1:0]           recv_cnt;
  logic                    rd_valid;
  logic [NW-1:0]           n_use;
  logic [NW-1:0]           n_calc;
  logic [NW-1:0]           addr_full;
  logic [VW-1:0]           q_reg;
  logic [VW-1:0]           w0, w1, w2;
  logic [VW-1:0]           rd_data;
  logic                    accept;
  psa_func_t               func;
  logic [IDX_W-1:0]        idx;
  logic                    wr_en;
  psa_ctl_t                emit_ctl;
  psa_ctl_t                geo_ctl;
  logic signed [DOT_W-1:0] geo_x, geo_y;
  psa_ctl_t                z_ctl;
  logic signed [Z_W-1:0]   z_val;
  logic signed [SUM_W-1:0] sum;
  logic [ANG_W-1:0]        wr;
  logic                    dg;
  logic                    fin;
  logic signed [WT_W-1:0]  wr_t;
  logic signed [WT_W-1:0]  wr_adj;
  logic signed [OFF_W-1:0] off;
  psa_result_t             res_next;
  psa_result_t             pend;
  logic                    pend_valid;
  psa_result_t             out_res;

  assign s_tready  = !busy && !rst;
  assign cfg_ready = !rst;
  assign accept    = s_tvalid && s_tready;
  assign func      = psa_func_t'(s_tuser);
  assign idx       = s_tdata[IDX_W-1:0];
  assign wr_en     = accept && (func == FUNC_LOAD) && (int'(idx) < MAX_VERTICES);
  assign m_tdata   = out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CNT_W'(4);
    end else if (cfg_valid && cfg_ready) begin
      vertex_count <= cfg_data;
    end
  end

  always_comb begin
    if (vertex_count < CNT_W'(MIN_VERTICES)) begin
      n_calc = NW'(MIN_VERTICES);
    end else if (int'(vertex_count) > MAX_VERTICES) begin
      n_calc = NW'(MAX_VERTICES);
    end else begin
      n_calc = NW'(vertex_count);
    end
  end

  // Read order: last vertex, then 0 .. n-1, then vertex 0 again.
  always_comb begin
    if (iss_cnt == '0) begin
      addr_full = n_use - NW'(1);
    end else if (iss_cnt == n_use + NW'(1)) begin
      addr_full = '0;
    end else begin
      addr_full = iss_cnt - NW'(1);
    end
  end

  psa_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_VERTICES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(idx)),
    .wr_data (s_tdata[IDX_W +: VW]),
    .rd_en   (issuing),
    .rd_addr (addr_full[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing  <= 1'b0;
      iss_cnt  <= '0;
      recv_cnt <= '0;
      rd_valid <= 1'b0;
      emit_ctl <= '0;
    end else begin
      rd_valid <= issuing;
      if (accept && (func == FUNC_QUERY)) begin
        issuing  <= 1'b1;
        iss_cnt  <= '0;
        recv_cnt <= '0;
      end else begin
        if (issuing) begin
          iss_cnt <= iss_cnt + NW'(1);
          if (iss_cnt == n_use + NW'(1)) begin
            issuing <= 1'b0;
          end
        end
        if (rd_valid) begin
          recv_cnt <= recv_cnt + NW'(1);
        end
      end
      emit_ctl.valid <= rd_valid && (recv_cnt >= NW'(2));
      emit_ctl.last  <= rd_valid && (recv_cnt == n_use + NW'(1));
      emit_ctl.degen <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (func == FUNC_QUERY)) begin
      q_reg <= s_tdata[IDX_W +: VW];
      n_use <= n_calc;
    end
    if (rd_valid) begin
      w0 <= w1;
      w1 <= w2;
      w2 <= rd_data;
    end
  end

  psa_vertex_pipe #(
    .COORD_BITS (COORD_BITS)
  ) u_geo (
    .clk     (clk),
    .rst     (rst),
    .in_ctl  (emit_ctl),
    .p0      (w0),
    .p1      (w1),
    .p2      (w2),
    .q       (q_reg),
    .out_ctl (geo_ctl),
    .out_x   (geo_x),
    .out_y   (geo_y)
  );

  psa_cordic u_atan (
    .clk     (clk),
    .rst     (rst),
    .in_ctl  (geo_ctl),
    .in_x    (geo_x),
    .in_y    (geo_y),
    .out_ctl (z_ctl),
    .out_z   (z_val)
  );

  // The wrapped sum is kept in range by one correction per vertex.
  always_comb begin
    wr_t = $signed(WT_W'(wr)) + WT_W'(z_val);
    if (wr_t < 0) begin
      wr_adj = wr_t + WT_W'(ANG_FOUR_PI);
    end else if (wr_t >= WT_W'(ANG_FOUR_PI)) begin
      wr_adj = wr_t - WT_W'(ANG_FOUR_PI);
    end else begin
      wr_adj = wr_t;
    end
  end

  always_comb begin
    off = OFF_W'(sum) + OFF_W'(ANG_TWO_PI);
    res_next.wrapped_angle = wr;
    res_next.degenerate    = 1'b0;
    res_next.clipped       = 1'b0;
    res_next.offset_angle  = off[ANG_W-1:0];
    if (off < 0) begin
      res_next.offset_angle = '0;
      res_next.clipped      = 1'b1;
    end else if (off > OFF_W'(ANG_FOUR_PI)) begin
      res_next.offset_angle = ANG_W'(ANG_FOUR_PI);
      res_next.clipped      = 1'b1;
    end
    if (dg) begin
      res_next = '0;
      res_next.degenerate = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (func == FUNC_QUERY)) begin
      sum <= '0;
      wr  <= '0;
      dg  <= 1'b0;
    end else if (z_ctl.valid) begin
      sum <= sum + SUM_W'(z_val);
      wr  <= wr_adj[ANG_W-1:0];
      dg  <= dg | z_ctl.degen;
    end
    if (fin) begin
      pend <= res_next;
    end
    if (pend_valid && (!m_tvalid || m_tready)) begin
      out_res <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      fin        <= 1'b0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      fin <= z_ctl.valid && z_ctl.last;
      if (accept && (func == FUNC_QUERY)) begin
        busy <= 1'b1;
      end
      if (fin) begin
        pend_valid <= 1'b1;
      end
      if (pend_valid && (!m_tvalid || m_tready)) begin
        m_tvalid   <= 1'b1;
        pend_valid <= 1'b0;
        busy       <= 1'b0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `PSA_ASSERT_IMP(a_pend_in_query, pend_valid, busy)
  `PSA_ASSERT_IMP(a_issue_in_query, issuing || rd_valid, busy)
  `PSA_ASSERT_IMP(a_emit_in_query, emit_ctl.valid || fin, busy)
  `PSA_ASSERT_NEXT(a_query_starts, accept && (func == FUNC_QUERY), busy && issuing)
  `PSA_ASSERT_IMP(a_last_is_valid, z_ctl.last || geo_ctl.last, z_ctl.valid || geo_ctl.valid)

endmodule

FILE: tb/tb.sv
// Self-checking testbench for polygon_solid_angle: vertex loads, point queries
// and vertex_count writes, checked against a behavioral solid angle predictor.
// Depends on psa_pkg and the polygon_solid_angle RTL.
`timescale 1ns / 1ps
module tb;
  import psa_pkg::*;

  typedef longint vec3_t [3];

  typedef struct {
    psa_func_t   func;
    logic [3:0]  idx;
    longint      x;
    longint      y;
    longint      z;
    bit          typed;
    psa_result_t want;
  } stim_row_t;

  localparam psa_result_t DEGEN_RESULT = '{clipped: 1'b0, degenerate: 1'b1,
                                           offset_angle: '0, wrapped_angle: '0};
  localparam longint Q_ONE = 65536;
  localparam longint C_MAX = 8388607;
  localparam longint C_MIN = -8388608;
  localparam longint FOUR_PI = 2 * longint'(ANG_TWO_PI);
  localparam int ATAN_Q27 [28] = '{
    105414357, 62229729, 32880480, 16690645, 8377711, 4192939, 2096981,
    1048555, 524285, 262144, 131072, 65536, 32768, 16384, 8192, 4096,
    2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [79:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  longint vertex_store [16][3];
  logic [CNT_W-1:0] vertex_count_q = 5'd4;
  psa_result_t angle_queue [$];
  stim_row_t stim_rows [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  polygon_solid_angle dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint fold_mag(longint v);
    return v < 0 ? -(v + 1) : v;
  endfunction

  function automatic int bit_len(longint m);
    int n;
    n = 0;
    while (m != 0) begin
      n++;
      m = m >> 1;
    end
    return n;
  endfunction

  function automatic bit normal_zero(vec3_t a, vec3_t b);
    return a[1] * b[2] == a[2] * b[1] && a[2] * b[0] == a[0] * b[2] &&
           a[0] * b[1] == a[1] * b[0];
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint edge_atan2(longint y, longint x);
    int s;
    longint z;
    longint t;
    longint xs;
    longint ys;
    if (x == 0 && y == 0) return 0;
    s = bit_len(fold_mag(x) | fold_mag(y));
    s = s > 30 ? s - 30 : 0;
    x = x >>> s;
    y = y >>> s;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = ANG_PI_HALF;
      end else begin
        x = -y; y = t; z = -ANG_PI_HALF;
      end
    end
    for (int i = 0; i < 28; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + ATAN_Q27[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ATAN_Q27[i];
      end
    end
    return z;
  endfunction

  function automatic psa_result_t predict_solid_angle(longint qx, longint qy, longint qz);
    int n;
    int ip;
    int inx;
    int s;
    int j1;
    int j2;
    longint q [3];
    vec3_t a, b, c, sa, sb, sc, uu, vv;
    longint m, det, dot, k, sum, off, wr;
    bit degen;
    bit clip;
    psa_result_t r;
    q = '{qx, qy, qz};
    n = vertex_count_q;
    if (n < 3) n = 3;
    if (n > 16) n = 16;
    sum = 0;
    degen = 0;
    clip = 0;
    for (int i = 0; i < n; i++) begin
      ip = i == 0 ? n - 1 : i - 1;
      inx = i + 1 == n ? 0 : i + 1;
      m = 0;
      for (int j = 0; j < 3; j++) begin
        a[j] = vertex_store[ip][j] - q[j];
        b[j] = vertex_store[i][j] - q[j];
        c[j] = vertex_store[inx][j] - q[j];
        m = m | fold_mag(a[j]) | fold_mag(b[j]) | fold_mag(c[j]);
      end
      if (normal_zero(a, b) || normal_zero(b, c)) begin
        degen = 1;
        continue;
      end
      s = bit_len(m);
      s = s > 14 ? s - 14 : 0;
      for (int j = 0; j < 3; j++) begin
        sa[j] = a[j] >>> s;
        sb[j] = b[j] >>> s;
        sc[j] = c[j] >>> s;
      end
      for (int j = 0; j < 3; j++) begin
        j1 = (j + 1) % 3;
        j2 = (j + 2) % 3;
        uu[j] = sb[j1] * sc[j2] - sb[j2] * sc[j1];
        vv[j] = sa[j1] * sb[j2] - sa[j2] * sb[j1];
      end
      det = sa[0] * uu[0] + sa[1] * uu[1] + sa[2] * uu[2];
      dot = uu[0] * vv[0] + uu[1] * vv[1] + uu[2] * vv[2];
      k = int_sqrt(sb[0] * sb[0] + sb[1] * sb[1] + sb[2] * sb[2]);
      sum = sum + edge_atan2((0 - det) * k, dot);
    end
    if (degen) return DEGEN_RESULT;
    off = sum + ANG_TWO_PI;
    if (off < 0) begin
      off = 0; clip = 1;
    end
    if (off > FOUR_PI) begin
      off = FOUR_PI; clip = 1;
    end
    wr = sum % FOUR_PI;
    if (wr < 0) wr = wr + FOUR_PI;
    r.wrapped_angle = wr[ANG_W-1:0];
    r.offset_angle = off[ANG_W-1:0];
    r.degenerate = 1'b0;
    r.clipped = clip;
    return r;
  endfunction

  task automatic send_item(stim_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= row.func;
    s_tdata <= {4'b0, row.z[23:0], row.y[23:0], row.x[23:0], row.idx};
    do @(posedge clk); while (!s_tready);
    if (row.func == FUNC_LOAD) begin
      vertex_store[row.idx] = '{row.x, row.y, row.z};
    end else if (row.typed) begin
      angle_queue = {angle_queue, row.want};
    end else begin
      angle_queue = {angle_queue, predict_solid_angle(row.x, row.y, row.z)};
    end
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (angle_queue.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (angle_queue.size() != 0) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      repeat (64) @(posedge clk);
    end
  endtask

  task automatic write_vertex_count(logic [CNT_W-1:0] value);
    s_tvalid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    vertex_count_q = value;
  endtask

  function automatic longint rand_coord();
    case ($urandom_range(3))
      0: return longint'($signed($urandom_range(16777215) - 8388608));
      1: return longint'($urandom_range(2 * Q_ONE)) - Q_ONE;
      2: return longint'($urandom_range(1024)) - 512;
      default: return longint'($urandom_range(64 * Q_ONE)) - 32 * Q_ONE;
    endcase
  endfunction

  function automatic stim_row_t rand_row();
    stim_row_t row;
    int pick;
    int n;
    pick = $urandom_range(99);
    n = vertex_count_q < 3 ? 3 : (vertex_count_q > 16 ? 16 : int'(vertex_count_q));
    row.typed = 0;
    row.want = DEGEN_RESULT;
    row.idx = 4'($urandom_range(15));
    row.func = pick < 30 ? FUNC_LOAD : FUNC_QUERY;
    row.x = rand_coord();
    row.y = rand_coord();
    row.z = rand_coord();
    if (pick >= 92) begin
      pick = $urandom_range(n - 1);
      row.x = vertex_store[pick][0];
      row.y = vertex_store[pick][1];
      row.z = vertex_store[pick][2];
    end
    return row;
  endfunction

  function automatic void add_row(psa_func_t f, int idx, longint x, longint y, longint z,
                                  bit typed);
    stim_row_t row;
    row.func = f;
    row.idx = 4'(idx);
    row.x = x;
    row.y = y;
    row.z = z;
    row.typed = typed;
    row.want = DEGEN_RESULT;
    stim_rows = {stim_rows, row};
  endfunction

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    psa_result_t got;
    psa_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = psa_result_t'(m_tdata);
      if (angle_queue.size() == 0) begin
        $error("result transaction with no query outstanding");
        errors++;
      end else begin
        want = angle_queue.pop_front();
        if (got.wrapped_angle !== want.wrapped_angle) begin
          $error("wrapped_angle expected %0d actual %0d", want.wrapped_angle,
                 got.wrapped_angle);
          errors++;
        end
        if (got.offset_angle !== want.offset_angle) begin
          $error("offset_angle expected %0d actual %0d", want.offset_angle,
                 got.offset_angle);
          errors++;
        end
        if (got.degenerate !== want.degenerate) begin
          $error("degenerate expected %0d actual %0d", want.degenerate, got.degenerate);
          errors++;
        end
        if (got.clipped !== want.clipped) begin
          $error("clipped expected %0d actual %0d", want.clipped, got.clipped);
          errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int phase_counts [3];
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Square with corners at +-Q_ONE in the z = 0 plane, then extreme coordinates in the other slots.
    add_row(FUNC_LOAD, 0, Q_ONE, Q_ONE, 0, 0);
    add_row(FUNC_LOAD, 1, -Q_ONE, Q_ONE, 0, 0);
    add_row(FUNC_LOAD, 2, -Q_ONE, -Q_ONE, 0, 0);
    add_row(FUNC_LOAD, 3, Q_ONE, -Q_ONE, 0, 0);
    add_row(FUNC_LOAD, 4, C_MAX, C_MAX, C_MAX, 0);
    add_row(FUNC_LOAD, 5, C_MIN, C_MIN, C_MIN, 0);
    for (int i = 6; i < 16; i++) begin
      add_row(FUNC_LOAD, i, (i % 2) ? C_MAX : C_MIN, (i % 3) ? C_MIN : C_MAX,
              i * Q_ONE - 8 * Q_ONE, 0);
    end
    add_row(FUNC_QUERY, 0, 0, 0, Q_ONE, 0);
    add_row(FUNC_QUERY, 0, 0, 0, -Q_ONE, 0);
    add_row(FUNC_QUERY, 0, 0, 0, 0, 0);
    add_row(FUNC_QUERY, 0, Q_ONE, Q_ONE, 0, 1);
    add_row(FUNC_QUERY, 0, Q_ONE, 0, 0, 1);
    add_row(FUNC_QUERY, 7, C_MAX, C_MAX, C_MAX, 0);
    add_row(FUNC_QUERY, 15, C_MIN, C_MIN, C_MIN, 0);
    foreach (stim_rows[i]) send_item(stim_rows[i]);

    write_vertex_count(5'd16);
    send_item('{FUNC_QUERY, 4'd0, 0, 0, Q_ONE, 1'b0, DEGEN_RESULT});
    write_vertex_count(5'd0);
    send_item('{FUNC_QUERY, 4'd0, 0, 0, Q_ONE, 1'b0, DEGEN_RESULT});
    write_vertex_count(5'd31);
    send_item('{FUNC_QUERY, 4'd0, 0, 0, -Q_ONE, 1'b0, DEGEN_RESULT});

    phase_counts = '{175, 175, 175};
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          write_vertex_count(5'd3);
          send_idle_pct = 26; recv_idle_pct = 57;
        end
        1: begin
          write_vertex_count(5'($urandom_range(4, 15)));
          send_idle_pct = 57; recv_idle_pct = 26;
        end
        default: begin
          write_vertex_count(5'd16);
          send_idle_pct = 0; recv_idle_pct = 0;
        end
      endcase
      repeat (phase_counts[p]) send_item(rand_row());
    end
    s_tvalid <= 1'b0;
    wait_drained();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
